// File: rtl/mvra_pkg.sv
// Package for the MSI vector range allocator: sizes, codes, request/response
// and chain token types. No dependencies.
`default_nettype none

package mvra_pkg;

    localparam int NUM_VECTORS = 64;
    localparam int IDX_W       = $clog2(NUM_VECTORS);
    localparam int RUN_W       = $clog2(NUM_VECTORS + 1);
    localparam int CNT_W       = 7;
    localparam int START_W     = 6;
    // wide enough for any index, count, and their sum without wrap
    localparam int EXT_W       = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

    typedef enum logic
    {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        STAT_OK          = 2'd0,
        STAT_NO_ROOM     = 2'd1,
        STAT_BAD_RELEASE = 2'd2
    } status_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_FINISH
    } state_t;

    typedef struct packed
    {
        cmd_t               cmd;
        logic [CNT_W-1:0]   req_count;
        logic [START_W-1:0] release_start;
    } req_t;

    typedef struct packed
    {
        status_t            status;
        logic [START_W-1:0] granted_start;
    } rsp_t;

    // request fields broadcast to every cell while a request is in work
    typedef struct packed
    {
        cmd_t               cmd;
        logic [CNT_W-1:0]   count;
        logic [EXT_W-1:0]   lo;
        logic [EXT_W-1:0]   hi;
        logic               en;
    } bcast_t;

    typedef struct packed
    {
        logic valid;
        logic set;
    } commit_t;

    // scan token handed from cell to cell
    typedef struct packed
    {
        logic               valid;
        logic [RUN_W-1:0]   run;
        logic               hit;
        logic [IDX_W-1:0]   last_idx;
        logic               bad;
    } tok_t;

endpackage

`default_nettype wire

// File: rtl/msi_vector_range_allocator.sv
// MSI vector range allocator top level: controller and the row of vector
// cells. Depends on mvra_pkg and mvra_cell.
// The scan token crosses the row of cells one cell per cycle; then the commit
// state updates the vector bits on success and the finish state loads the response,
// waiting while the response is stalled. A new request is stalled until that load.
// Reset: all vectors free, no request in work, no response pending.
`default_nettype none

module msi_vector_range_allocator
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire           req_valid,
    output logic          req_stall,
    input  mvra_pkg::req_t req_data,
    output logic          rsp_valid,
    input  wire           rsp_stall,
    output mvra_pkg::rsp_t rsp_data
);
    import mvra_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic               launch_reg;
    cmd_t               cmd_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [EXT_W-1:0]   lo_reg;
    logic [EXT_W-1:0]   hi_reg;
    logic               en_reg;
    logic               prebad_reg;
    logic               commit_en_reg;
    status_t            status_reg;
    logic [START_W-1:0] granted_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic               accept;
    logic               load_rsp;
    logic [EXT_W-1:0]   start_ext;
    logic [EXT_W-1:0]   count_ext;
    logic               prebad;
    logic [EXT_W-1:0]   alloc_lo;
    logic [EXT_W-1:0]   last_ext;

    bcast_t             bcast;
    commit_t            commit;
    tok_t               chain [NUM_VECTORS+1];
    tok_t               tail;
    logic [NUM_VECTORS-1:0] tok_vld;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign load_rsp  = (state_reg == ST_FINISH) && (!rsp_valid_reg || !rsp_stall);

    assign start_ext = EXT_W'(req_data.release_start);
    assign count_ext = EXT_W'(req_data.req_count);
    assign prebad    = (start_ext >= EXT_W'(NUM_VECTORS)) ||
                       (count_ext > (EXT_W'(NUM_VECTORS) - start_ext));

    assign tail      = chain[NUM_VECTORS];
    assign last_ext  = EXT_W'(tail.last_idx);
    assign alloc_lo  = last_ext - EXT_W'(count_reg) + EXT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tail.valid)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (load_rsp)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            commit_en_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= accept;
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (state_reg == ST_SCAN && tail.valid)
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    commit_en_reg <= tail.hit;
                end
                else
                begin
                    commit_en_reg <= !prebad_reg && !tail.bad && en_reg;
                end
            end
            else if (state_reg == ST_COMMIT)
            begin
                commit_en_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= req_data.cmd;
            count_reg  <= req_data.req_count;
            lo_reg     <= start_ext;
            hi_reg     <= start_ext + count_ext - EXT_W'(1);
            en_reg     <= (req_data.req_count != '0);
            prebad_reg <= prebad;
        end
        else if (state_reg == ST_SCAN && tail.valid)
        begin
            if (cmd_reg == CMD_ALLOC)
            begin
                status_reg  <= tail.hit ? STAT_OK : STAT_NO_ROOM;
                lo_reg      <= alloc_lo;
                hi_reg      <= last_ext;
                granted_reg <= tail.hit ? alloc_lo[START_W-1:0] : '0;
            end
            else
            begin
                status_reg  <= (prebad_reg || tail.bad) ? STAT_BAD_RELEASE : STAT_OK;
                granted_reg <= '0;
            end
        end
        if (load_rsp)
        begin
            rsp_reg.status        <= status_reg;
            rsp_reg.granted_start <= granted_reg;
        end
    end

    assign bcast.cmd   = cmd_reg;
    assign bcast.count = count_reg;
    assign bcast.lo    = lo_reg;
    assign bcast.hi    = hi_reg;
    assign bcast.en    = en_reg;

    assign commit.valid = (state_reg == ST_COMMIT) && commit_en_reg;
    assign commit.set   = (cmd_reg == CMD_ALLOC);

    always_comb
    begin
        chain[0]          = '0;
        chain[0].valid    = launch_reg;
    end

    for (genvar i = 0; i < NUM_VECTORS; i++)
    begin : g_cell
        mvra_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (IDX_W'(i)),
            .req     (bcast),
            .commit  (commit),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
        assign tok_vld[i] = chain[i+1].valid;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    property p_single_token;
        @(posedge clk) disable iff (!rst_n) $onehot0(tok_vld);
    endproperty
    a_single_token: assert property (p_single_token)
        else $error("more than one scan token in the row");

    property p_tail_in_scan;
        @(posedge clk) disable iff (!rst_n) tail.valid |-> (state_reg == ST_SCAN);
    endproperty
    a_tail_in_scan: assert property (p_tail_in_scan)
        else $error("scan token left the row outside a scan");

    property p_rsp_from_finish;
        @(posedge clk) disable iff (!rst_n)
            load_rsp |=> (rsp_valid && state_reg == ST_IDLE);
    endproperty
    a_rsp_from_finish: assert property (p_rsp_from_finish)
        else $error("result load did not end the request");

    property p_grant_zero;
        @(posedge clk) disable iff (!rst_n)
            (rsp_valid && rsp_data.status != STAT_OK) |-> (rsp_data.granted_start == '0);
    endproperty
    a_grant_zero: assert property (p_grant_zero)
        else $error("granted start nonzero on a failed request");

endmodule

`default_nettype wire

// File: rtl/mvra_cell.sv
// One vector cell: holds the in-use bit of one vector and advances the scan
// token by one position per cycle. Depends on mvra_pkg.
`default_nettype none

module mvra_cell
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire [mvra_pkg::IDX_W-1:0] idx,
    input  mvra_pkg::bcast_t        req,
    input  mvra_pkg::commit_t       commit,
    input  mvra_pkg::tok_t          tok_in,
    output mvra_pkg::tok_t          tok_out
);
    import mvra_pkg::*;

    logic             in_use_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic [EXT_W-1:0] idx_ext;
    logic             in_range;
    logic [RUN_W-1:0] run_nxt;
    logic             hit_now;

    assign idx_ext  = EXT_W'(idx);
    assign in_range = (idx_ext >= req.lo) && (idx_ext <= req.hi);
    assign run_nxt  = in_use_reg ? '0 : tok_in.run + RUN_W'(1);
    assign hit_now  = (req.cmd == CMD_ALLOC) && (req.count != '0) &&
                      (EXT_W'(run_nxt) == EXT_W'(req.count));

    always_comb
    begin
        tok_next          = tok_in;
        tok_next.run      = run_nxt;
        tok_next.hit      = tok_in.hit | hit_now;
        // first cell where the run reaches the count marks the run end
        tok_next.last_idx = (!tok_in.hit && hit_now) ? idx : tok_in.last_idx;
        tok_next.bad      = tok_in.bad | ((req.cmd == CMD_RELEASE) && req.en &&
                                          in_range && !in_use_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= '0;
            in_use_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (commit.valid && in_range)
            begin
                in_use_reg <= commit.set;
            end
        end
    end

    assign tok_out = tok_reg;

    always_ff @(posedge clk)
    begin
        if (rst_n && tok_in.valid)
        begin
            assert (!(tok_in.hit && hit_now && tok_next.last_idx != tok_in.last_idx))
            else $error("run end moved after a hit");
        end
    end

    property p_commit_no_scan;
        @(posedge clk) disable iff (!rst_n) commit.valid |-> !tok_in.valid;
    endproperty
    a_commit_no_scan: assert property (p_commit_no_scan)
        else $error("commit while scan token in cell");

    property p_set_needs_free;
        @(posedge clk) disable iff (!rst_n)
            (commit.valid && commit.set && in_range) |-> !in_use_reg;
    endproperty
    a_set_needs_free: assert property (p_set_needs_free)
        else $error("allocation over a vector in use");

    property p_clear_needs_used;
        @(posedge clk) disable iff (!rst_n)
            (commit.valid && !commit.set && in_range) |-> in_use_reg;
    endproperty
    a_clear_needs_used: assert property (p_clear_needs_used)
        else $error("release of a free vector committed");

endmodule

`default_nettype wire
